@@ src/hmc_pkg.sv @@
package hmc_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_HAND,
        MODE_WAIT,
        MODE_SEND
    } mode_t;

    localparam int ADDR_W      = 8;
    localparam int TICK_W      = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT  = 1'b1;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd2000;

    // event opcodes
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_CTRL = 2'd1;
    localparam logic [1:0] OP_PHY  = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    // received frame kinds
    localparam logic [1:0] FK_ACK  = 2'd0;
    localparam logic [1:0] FK_NACK = 2'd1;
    localparam logic [1:0] PK_DATA = 2'd0;

    // result kinds
    localparam logic [1:0] KIND_CTRL = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    // upper-layer status codes
    localparam logic [1:0] ST_SUCCESS = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_FAILED  = 2'd2;
    localparam logic [1:0] ST_DATA    = 2'd3;

    // control frame types
    localparam logic [1:0] CT_ACK = 2'd0;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        frame_kind;
        logic [ADDR_W-1:0] frame_to;
        logic [ADDR_W-1:0] frame_from;
        logic [ADDR_W-1:0] req_addr;
    } item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        status;
        logic [1:0]        ctrl_type;
        logic [ADDR_W-1:0] out_to;
        logic [ADDR_W-1:0] out_from;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } result_pair_t;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  room;
    } fifo_status_t;

endpackage

@@ src/hmc_if.sv @@
interface hmc_evt_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [1:0]                 frame_kind;
    logic [hmc_pkg::ADDR_W-1:0] frame_to;
    logic [hmc_pkg::ADDR_W-1:0] frame_from;
    logic [hmc_pkg::ADDR_W-1:0] req_addr;

    modport source (output valid, output op, output frame_kind, output frame_to,
                    output frame_from, output req_addr, input ready);
    modport sink   (input valid, input op, input frame_kind, input frame_to,
                    input frame_from, input req_addr, output ready);
endinterface

interface hmc_res_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [1:0]                 status;
    logic [1:0]                 ctrl_type;
    logic [hmc_pkg::ADDR_W-1:0] out_to;
    logic [hmc_pkg::ADDR_W-1:0] out_from;
    logic                       last;

    modport source (output valid, output kind, output status, output ctrl_type,
                    output out_to, output out_from, output last, input ready);
    modport sink   (input valid, input kind, input status, input ctrl_type,
                    input out_to, input out_from, input last, output ready);
endinterface

@@ src/hmc_core.sv @@
module hmc_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hmc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                fire,
    input  hmc_pkg::item_t                      item,
    output hmc_pkg::result_pair_t               pair
);

    logic [hmc_pkg::ADDR_W-1:0] own_addr_reg;
    logic [hmc_pkg::TICK_W-1:0] timeout_reg;
    hmc_pkg::mode_t             mode_reg, mode_next;
    logic [hmc_pkg::ADDR_W-1:0] peer_reg, peer_next;
    logic [hmc_pkg::TICK_W-1:0] elapsed_reg, elapsed_next;

    logic over_timeout;
    logic under_timeout;
    logic for_us;
    logic from_peer;

    assign over_timeout  = elapsed_reg > timeout_reg;
    assign under_timeout = elapsed_reg < timeout_reg;
    assign for_us        = item.frame_to == own_addr_reg;
    assign from_peer     = item.frame_from == peer_reg;

    always_comb
    begin
        hmc_pkg::result_t frame_r;
        hmc_pkg::result_t stat_r;

        mode_next    = mode_reg;
        peer_next    = peer_reg;
        elapsed_next = elapsed_reg;
        pair         = '0;

        // frame to the current peer; the peer may change below, so set per arm
        frame_r          = '0;
        frame_r.out_to   = peer_reg;
        frame_r.out_from = own_addr_reg;
        stat_r           = '0;
        stat_r.kind      = hmc_pkg::KIND_STAT;

        unique case (item.op)
            hmc_pkg::OP_TICK:
            begin
                if (elapsed_reg != '1)
                begin
                    elapsed_next = elapsed_reg + hmc_pkg::TICK_W'(1);
                end
            end
            hmc_pkg::OP_SEND:
            begin
                if (mode_reg != hmc_pkg::MODE_IDLE && under_timeout)
                begin
                    pair.num           = 2'd1;
                    pair.first         = stat_r;
                    pair.first.status  = hmc_pkg::ST_BUSY;
                end
                else
                begin
                    peer_next          = item.req_addr;
                    mode_next          = hmc_pkg::MODE_HAND;
                    elapsed_next       = '0;
                    pair.num           = 2'd1;
                    pair.first         = frame_r;
                    pair.first.kind    = hmc_pkg::KIND_CTRL;
                    pair.first.out_to  = item.req_addr;
                end
            end
            hmc_pkg::OP_PHY:
            begin
                priority if (over_timeout)
                begin
                    mode_next         = hmc_pkg::MODE_IDLE;
                    elapsed_next      = '0;
                    pair.num          = 2'd1;
                    pair.first        = stat_r;
                    pair.first.status = hmc_pkg::ST_FAILED;
                end
                else if (item.frame_kind == hmc_pkg::PK_DATA
                         && mode_reg == hmc_pkg::MODE_WAIT && for_us && from_peer)
                begin
                    // acknowledge the data frame, then hand it up
                    mode_next          = hmc_pkg::MODE_IDLE;
                    elapsed_next       = '0;
                    pair.num           = 2'd2;
                    pair.first         = frame_r;
                    pair.first.kind    = hmc_pkg::KIND_CTRL;
                    pair.second        = stat_r;
                    pair.second.status = hmc_pkg::ST_DATA;
                end
                else
                begin
                    pair.num = 2'd0;
                end
            end
            hmc_pkg::OP_CTRL:
            begin
                priority if (!for_us)
                begin
                    pair.num = 2'd0;
                end
                else if (mode_reg == hmc_pkg::MODE_IDLE
                         && item.frame_kind == hmc_pkg::FK_ACK)
                begin
                    peer_next          = item.frame_from;
                    mode_next          = hmc_pkg::MODE_WAIT;
                    elapsed_next       = '0;
                    pair.num           = 2'd1;
                    pair.first         = frame_r;
                    pair.first.kind    = hmc_pkg::KIND_CTRL;
                    pair.first.out_to  = item.frame_from;
                end
                else if (mode_reg == hmc_pkg::MODE_HAND && from_peer)
                begin
                    priority if (over_timeout)
                    begin
                        mode_next         = hmc_pkg::MODE_IDLE;
                        elapsed_next      = '0;
                        pair.num          = 2'd1;
                        pair.first        = stat_r;
                        pair.first.status = hmc_pkg::ST_FAILED;
                    end
                    else if (item.frame_kind == hmc_pkg::FK_ACK)
                    begin
                        mode_next       = hmc_pkg::MODE_SEND;
                        elapsed_next    = '0;
                        pair.num        = 2'd1;
                        pair.first      = frame_r;
                        pair.first.kind = hmc_pkg::KIND_DATA;
                    end
                    else
                    begin
                        pair.num = 2'd0;
                    end
                end
                else if (mode_reg == hmc_pkg::MODE_SEND && from_peer)
                begin
                    priority if (item.frame_kind == hmc_pkg::FK_ACK)
                    begin
                        mode_next         = hmc_pkg::MODE_IDLE;
                        elapsed_next      = '0;
                        pair.num          = 2'd1;
                        pair.first        = stat_r;
                        pair.first.status = hmc_pkg::ST_SUCCESS;
                    end
                    else if (item.frame_kind == hmc_pkg::FK_NACK && under_timeout)
                    begin
                        // retransmit, timer keeps running
                        pair.num        = 2'd1;
                        pair.first      = frame_r;
                        pair.first.kind = hmc_pkg::KIND_DATA;
                    end
                    else if (item.frame_kind == hmc_pkg::FK_NACK)
                    begin
                        mode_next         = hmc_pkg::MODE_IDLE;
                        elapsed_next      = '0;
                        pair.num          = 2'd1;
                        pair.first        = stat_r;
                        pair.first.status = hmc_pkg::ST_FAILED;
                    end
                    else
                    begin
                        pair.num = 2'd0;
                    end
                end
                else
                begin
                    pair.num = 2'd0;
                end
            end
            default:
            begin
                pair.num = 2'd0;
            end
        endcase

        // mark the final result of this event
        if (pair.num == 2'd2)
        begin
            pair.second.last = 1'b1;
        end
        else if (pair.num == 2'd1)
        begin
            pair.first.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= '0;
            timeout_reg  <= hmc_pkg::TIMEOUT_RESET;
            mode_reg     <= hmc_pkg::MODE_IDLE;
            peer_reg     <= '0;
            elapsed_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hmc_pkg::REG_OWN_ADDR: own_addr_reg <= cfg_data[hmc_pkg::ADDR_W-1:0];
                    hmc_pkg::REG_TIMEOUT:  timeout_reg  <= cfg_data[hmc_pkg::TICK_W-1:0];
                    default:               own_addr_reg <= own_addr_reg;
                endcase
            end
            if (fire)
            begin
                mode_reg    <= mode_next;
                peer_reg    <= peer_next;
                elapsed_reg <= elapsed_next;
            end
        end
    end

endmodule

@@ src/hmc_result_fifo.sv @@
module hmc_result_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hmc_pkg::result_pair_t pair,
    output hmc_pkg::fifo_status_t stat,
    hmc_res_if.source             res
);

    hmc_pkg::result_t                entry_reg [hmc_pkg::FIFO_DEPTH];
    logic [hmc_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [hmc_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [hmc_pkg::FIFO_CNT_W-1:0]  count_reg, count_next;
    logic [hmc_pkg::FIFO_CNT_W-1:0]  push_num;
    logic                            pop;
    hmc_pkg::result_t                head;

    assign push_num    = push ? hmc_pkg::FIFO_CNT_W'(pair.num) : '0;
    assign pop         = res.valid && res.ready;
    assign wr_ptr_next = wr_ptr_reg + hmc_pkg::FIFO_PTR_W'(push_num);
    assign count_next  = count_reg + push_num - hmc_pkg::FIFO_CNT_W'(pop);

    // room for a full pair of results
    assign stat.count = count_reg;
    assign stat.room  = count_reg <= hmc_pkg::FIFO_CNT_W'(hmc_pkg::FIFO_DEPTH - 2);

    assign head          = entry_reg[rd_ptr_reg];
    assign res.valid     = count_reg != '0;
    assign res.kind      = head.kind;
    assign res.status    = head.status;
    assign res.ctrl_type = head.ctrl_type;
    assign res.out_to    = head.out_to;
    assign res.out_from  = head.out_from;
    assign res.last      = head.last;

    always_ff @(posedge clk)
    begin
        if (push && pair.num != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= pair.first;
        end
        if (push && pair.num == 2'd2)
        begin
            entry_reg[wr_ptr_reg + hmc_pkg::FIFO_PTR_W'(1)] <= pair.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + hmc_pkg::FIFO_PTR_W'(1);
            end
        end
    end

endmodule

@@ src/handshake_mac_controller.sv @@
// Channel  | Dir | Payload                                             | Transfer
// ---------+-----+-----------------------------------------------------+-------------------
// evt      | in  | op, frame_kind, frame_to, frame_from, req_addr      | valid && ready
// res      | out | kind, status, ctrl_type, out_to, out_from, last     | valid && ready
// cfg      | in  | cfg_index (0 own_addr, 1 timeout_ticks), cfg_data   | cfg_we
//
// An event transfer lands in the input register; the event logic then runs on it and
// its zero to two results enter a four-entry result queue, so one event a cycle while the
// queue has room. A result is offered once it has been written into the result queue.
// The result queue drains one result per cycle while res.ready is high; evt stalls only
// while the queue lacks room for two results.
// rst_n asynchronously clears mode, peer, timer, queue and config to reset values.
module handshake_mac_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    hmc_evt_if.sink                         evt,
    hmc_res_if.source                       res
);

    logic                  item_valid_reg;
    hmc_pkg::item_t        item_reg;
    logic                  fire;
    hmc_pkg::result_pair_t pair;
    hmc_pkg::fifo_status_t fifo_stat;

    // process the held event once the queue can take both of its possible results
    assign fire      = item_valid_reg && fifo_stat.room;
    assign evt.ready = !item_valid_reg || fire;

    // input register: load on each transfer, drop once processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            item_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            item_reg.op         <= evt.op;
            item_reg.frame_kind <= evt.frame_kind;
            item_reg.frame_to   <= evt.frame_to;
            item_reg.frame_from <= evt.frame_from;
            item_reg.req_addr   <= evt.req_addr;
        end
    end

    // mode, peer and timer live in the core; it decides results per event
    hmc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item_reg),
        .pair      (pair)
    );

    // hold results until the sink takes them
    hmc_result_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .pair  (pair),
        .stat  (fifo_stat),
        .res   (res)
    );

    // the queue never overfills
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.count <= hmc_pkg::FIFO_CNT_W'(hmc_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    // a processed event with results leaves the queue non-empty
    a_results_queued: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pair.num != 2'd0 |=> fifo_stat.count != '0)
        else $error("results of an event were lost");

    // a tick never produces a result
    a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item_reg.op == hmc_pkg::OP_TICK |-> pair.num == 2'd0)
        else $error("tick produced a result");

endmodule

@@ tb/sv/mac_event_checker.sv @@
`timescale 1ns / 100ps

module mac_event_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    hmc_evt_if                              evt,
    hmc_res_if                              res,
    output int                              mismatches,
    output int                              replies_due,
    output int                              replies_seen
);

    localparam int MAX_REPORTS = 40;

    hmc_pkg::mode_t                      mode          = hmc_pkg::MODE_IDLE;
    logic [hmc_pkg::ADDR_W-1:0]          peer          = '0;
    logic [hmc_pkg::ADDR_W-1:0]          own_addr      = '0;
    logic [hmc_pkg::TICK_W-1:0]          elapsed       = '0;
    logic [hmc_pkg::TICK_W-1:0]          timeout_ticks = hmc_pkg::TIMEOUT_RESET;

    hmc_pkg::result_t replies[$];
    hmc_pkg::result_t step_out[2];
    int               step_n   = 0;
    int               fail_cnt = 0;
    int               seen_cnt = 0;

    function automatic void emit(input logic [1:0] kind, input logic [1:0] status,
                                 input logic [hmc_pkg::ADDR_W-1:0] to,
                                 input logic [hmc_pkg::ADDR_W-1:0] from);
        hmc_pkg::result_t r;
        r.kind      = kind;
        r.status    = status;
        r.ctrl_type = hmc_pkg::CT_ACK;
        r.out_to    = to;
        r.out_from  = from;
        r.last      = 1'b0;
        step_out[step_n] = r;
        step_n++;
    endfunction

    function automatic void end_exchange(input logic [1:0] status);
        mode    = hmc_pkg::MODE_IDLE;
        elapsed = '0;
        emit(hmc_pkg::KIND_STAT, status, '0, '0);
    endfunction

    // work out the results of one event and queue them in order
    function automatic void predict_event(input hmc_pkg::item_t it);
        hmc_pkg::result_t r;
        step_n = 0;
        case (it.op)
            hmc_pkg::OP_TICK:
            begin
                if (elapsed != '1)
                    elapsed++;
            end
            hmc_pkg::OP_SEND:
            begin
                if (mode != hmc_pkg::MODE_IDLE && elapsed < timeout_ticks)
                    emit(hmc_pkg::KIND_STAT, hmc_pkg::ST_BUSY, '0, '0);
                else
                begin
                    peer    = it.req_addr;
                    mode    = hmc_pkg::MODE_HAND;
                    elapsed = '0;
                    emit(hmc_pkg::KIND_CTRL, '0, peer, own_addr);
                end
            end
            hmc_pkg::OP_PHY:
            begin
                if (elapsed > timeout_ticks)
                    end_exchange(hmc_pkg::ST_FAILED);
                else if (it.frame_kind == hmc_pkg::PK_DATA && mode == hmc_pkg::MODE_WAIT &&
                         it.frame_to == own_addr && it.frame_from == peer)
                begin
                    elapsed = '0;
                    emit(hmc_pkg::KIND_CTRL, '0, peer, own_addr);
                    end_exchange(hmc_pkg::ST_DATA);
                end
            end
            default:
            begin
                if (it.frame_to == own_addr)
                begin
                    if (mode == hmc_pkg::MODE_IDLE && it.frame_kind == hmc_pkg::FK_ACK)
                    begin
                        peer    = it.frame_from;
                        mode    = hmc_pkg::MODE_WAIT;
                        elapsed = '0;
                        emit(hmc_pkg::KIND_CTRL, '0, peer, own_addr);
                    end
                    else if (mode == hmc_pkg::MODE_HAND && peer == it.frame_from)
                    begin
                        if (elapsed > timeout_ticks)
                            end_exchange(hmc_pkg::ST_FAILED);
                        else if (it.frame_kind == hmc_pkg::FK_ACK)
                        begin
                            mode    = hmc_pkg::MODE_SEND;
                            elapsed = '0;
                            emit(hmc_pkg::KIND_DATA, '0, peer, own_addr);
                        end
                    end
                    else if (mode == hmc_pkg::MODE_SEND && peer == it.frame_from)
                    begin
                        if (it.frame_kind == hmc_pkg::FK_ACK)
                            end_exchange(hmc_pkg::ST_SUCCESS);
                        else if (it.frame_kind == hmc_pkg::FK_NACK)
                        begin
                            if (elapsed < timeout_ticks)
                                emit(hmc_pkg::KIND_DATA, '0, peer, own_addr);
                            else
                                end_exchange(hmc_pkg::ST_FAILED);
                        end
                    end
                end
            end
        endcase
        for (int i = 0; i < step_n; i++)
        begin
            r      = step_out[i];
            r.last = (i == step_n - 1);
            replies.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : watch
        hmc_pkg::result_t got;
        hmc_pkg::result_t want;
        hmc_pkg::item_t   it;
        if (!rst_n)
        begin
            mode          = hmc_pkg::MODE_IDLE;
            peer          = '0;
            own_addr      = '0;
            elapsed       = '0;
            timeout_ticks = hmc_pkg::TIMEOUT_RESET;
            replies.delete();
        end
        else
        begin
            // results leave before new events arrive: a result is never caused
            // by the event taken at the same edge
            if (res.valid && res.ready)
            begin
                got.kind      = res.kind;
                got.status    = res.status;
                got.ctrl_type = res.ctrl_type;
                got.out_to    = res.out_to;
                got.out_from  = res.out_from;
                got.last      = res.last;
                seen_cnt++;
                if (replies.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("%0t ns: unexpected result, expected none, got %h",
                                 $time, got);
                end
                else
                begin
                    want = replies.pop_front();
                    check_field("kind", 8'(want.kind), 8'(got.kind));
                    check_field("status", 8'(want.status), 8'(got.status));
                    check_field("ctrl_type", 8'(want.ctrl_type), 8'(got.ctrl_type));
                    check_field("out_to", want.out_to, got.out_to);
                    check_field("out_from", want.out_from, got.out_from);
                    check_field("last", 8'(want.last), 8'(got.last));
                end
            end
            if (evt.valid && evt.ready)
            begin
                it.op         = evt.op;
                it.frame_kind = evt.frame_kind;
                it.frame_to   = evt.frame_to;
                it.frame_from = evt.frame_from;
                it.req_addr   = evt.req_addr;
                predict_event(it);
            end
            if (cfg_we)
            begin
                if (cfg_index == hmc_pkg::REG_OWN_ADDR)
                    own_addr = cfg_data[hmc_pkg::ADDR_W-1:0];
                else if (cfg_index == hmc_pkg::REG_TIMEOUT)
                    timeout_ticks = cfg_data;
            end
        end
        mismatches   <= fail_cnt;
        replies_due  <= replies.size();
        replies_seen <= seen_cnt;
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    // frame kinds the package leaves unnamed
    localparam logic [1:0] FK_SENSE = 2'd2;
    localparam logic [1:0] FK_OTHER = 2'd3;
    localparam logic [1:0] PK_DROP  = 2'd1;
    localparam logic [1:0] PK_SENSE = 2'd2;
    localparam logic [1:0] PK_OTHER = 2'd3;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 225;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [hmc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [hmc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    hmc_evt_if evt_ch ();
    hmc_res_if res_ch ();

    int mismatches;
    int replies_due;
    int replies_seen;

    // stimulus knobs; the receiver process reads the stall rate and the hold request
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    bit          hold_off_req    = 1'b0;
    logic [7:0]  cur_own         = '0;
    logic [31:0] cur_timeout     = hmc_pkg::TIMEOUT_RESET;
    int          tick_cap        = 6;
    logic [7:0]  prev_peer       = '0;
    int          items_sent      = 0;
    int          settings_used   = 1;

    // per-phase register values and idle patterns; -1 asks for a random address
    int          own_tab   [NUM_PHASES] = '{0, 255, 90, -1, 165, -1, 60, -1};
    logic [31:0] tmo_tab   [NUM_PHASES] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF,
                                            32'd4, 32'd2000, 32'd1};
    int          sidle_tab [NUM_PHASES] = '{0, 88, 0, 28, 0, 88, 0, 28};
    int          rstall_tab[NUM_PHASES] = '{0, 0, 88, 28, 0, 0, 88, 28};

    always #6 clk = ~clk;

    handshake_mac_controller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (evt_ch),
        .res       (res_ch)
    );

    mac_event_checker u_mac_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .evt          (evt_ch),
        .res          (res_ch),
        .mismatches   (mismatches),
        .replies_due  (replies_due),
        .replies_seen (replies_seen)
    );

    // Offer one event; idle first at the current sender rate, then hold valid
    // until the transfer happens. Valid stays high straight into the next
    // event when no idle cycle is drawn.
    task automatic send_event(input logic [1:0] op, input logic [1:0] fk,
                              input logic [7:0] to, input logic [7:0] from,
                              input logic [7:0] dest);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid      <= 1'b1;
        evt_ch.op         <= op;
        evt_ch.frame_kind <= fk;
        evt_ch.frame_to   <= to;
        evt_ch.frame_from <= from;
        evt_ch.req_addr   <= dest;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // ticks carry random payload so that those bits toggle too
    task automatic run_ticks(input int n);
        repeat (n)
            send_event(hmc_pkg::OP_TICK, 2'($urandom()), 8'($urandom()), 8'($urandom()),
                       8'($urandom()));
    endtask

    // Drop valid and wait for every expected result, then let the input
    // register drain an event that causes no result.
    task automatic settle();
        int waited;
        waited = 0;
        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (replies_due != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hmc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [hmc_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram both registers with the block idle. Scale tick runs to the
    // timeout so that the boundaries around it are hit often.
    task automatic configure(input logic [7:0] own, input logic [31:0] tmo);
        settle();
        write_reg(hmc_pkg::REG_OWN_ADDR, {24'd0, own});
        write_reg(hmc_pkg::REG_TIMEOUT, tmo);
        cur_own     = own;
        cur_timeout = tmo;
        tick_cap    = (tmo <= 32'd4) ? int'(tmo) + 2 : 6;
        settings_used++;
    endtask

    // mostly our own address, sometimes a stranger's
    function automatic logic [7:0] pick_to();
        return ($urandom_range(99) < 85) ? cur_own : 8'($urandom());
    endfunction

    // mostly the intended peer; the previous peer now and then lets an
    // abandoned exchange be finished, the rest is noise
    function automatic logic [7:0] pick_from(input logic [7:0] p);
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return p;
        if (r < 90)
            return prev_peer;
        return 8'($urandom());
    endfunction

    function automatic logic [1:0] mostly(input logic [1:0] code, input int pct);
        return ($urandom_range(99) < pct) ? code : 2'($urandom());
    endfunction

    // Random part of one phase: well-formed exchanges with random content,
    // seasoned with busy requests, stray frames and pure noise.
    task automatic run_phase(input int n);
        int         start;
        int         noise;
        int         scen;
        int         rounds;
        logic [7:0] p;
        start = items_sent;
        noise = 0;
        while (items_sent - start - noise < n)
        begin
            scen = $urandom_range(9);
            p    = 8'($urandom());
            if (scen < 4)
            begin
                // we start: request, peer ACK, a few NACK rounds, final ACK
                send_event(hmc_pkg::OP_SEND, 2'($urandom()), 8'($urandom()),
                           8'($urandom()), p);
                run_ticks($urandom_range(tick_cap));
                if ($urandom_range(99) < 15)
                    send_event(hmc_pkg::OP_SEND, 2'($urandom()), 8'($urandom()),
                               8'($urandom()), pick_from(p));
                send_event(hmc_pkg::OP_CTRL, mostly(hmc_pkg::FK_ACK, 80), pick_to(),
                           pick_from(p), 8'($urandom()));
                rounds = $urandom_range(3);
                repeat (rounds)
                begin
                    run_ticks($urandom_range(tick_cap));
                    send_event(hmc_pkg::OP_CTRL, mostly(hmc_pkg::FK_NACK, 85), pick_to(),
                               pick_from(p), 8'($urandom()));
                end
                run_ticks($urandom_range(tick_cap));
                send_event(hmc_pkg::OP_CTRL, mostly(hmc_pkg::FK_ACK, 75), pick_to(),
                           pick_from(p), 8'($urandom()));
            end
            else if (scen < 8)
            begin
                // peer starts: its ACK, then its data frame
                send_event(hmc_pkg::OP_CTRL, mostly(hmc_pkg::FK_ACK, 85), pick_to(), p,
                           8'($urandom()));
                run_ticks($urandom_range(tick_cap));
                if ($urandom_range(99) < 20)
                    send_event(hmc_pkg::OP_SEND, 2'($urandom()), 8'($urandom()),
                               8'($urandom()), 8'($urandom()));
                send_event(hmc_pkg::OP_PHY, mostly(hmc_pkg::PK_DATA, 80), pick_to(),
                           pick_from(p), 8'($urandom()));
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_event(2'($urandom()), 2'($urandom()),
                               ($urandom_range(1) == 0) ? cur_own : 8'($urandom()),
                               8'($urandom()), 8'($urandom()));
                    noise++;
                end
            end
            prev_peer = p;
        end
    endtask

    // Receiver: stall at the current rate; on request hold off for a long
    // stretch so the result queue fills and the event channel backs up.
    initial
    begin : receiver
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        logic [7:0] own;
        evt_ch.valid      <= 1'b0;
        evt_ch.op         <= hmc_pkg::OP_TICK;
        evt_ch.frame_kind <= hmc_pkg::FK_ACK;
        evt_ch.frame_to   <= '0;
        evt_ch.frame_from <= '0;
        evt_ch.req_addr   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset values: own address 0, timeout 2000.
        // Full initiator exchange with one retransmit and ignored frames between.
        send_event(hmc_pkg::OP_SEND, hmc_pkg::FK_ACK, 8'h00, 8'h00, 8'hFF);
        send_event(hmc_pkg::OP_SEND, hmc_pkg::FK_ACK, 8'h00, 8'h00, 8'h01);   // busy
        send_event(hmc_pkg::OP_CTRL, hmc_pkg::FK_ACK, 8'h00, 8'hFF, 8'h00);   // data sending
        send_event(hmc_pkg::OP_CTRL, hmc_pkg::FK_NACK, 8'h00, 8'hFF, 8'h00);  // retransmit
        send_event(hmc_pkg::OP_CTRL, FK_SENSE, 8'h00, 8'hFF, 8'h00);
        send_event(hmc_pkg::OP_CTRL, FK_OTHER, 8'h00, 8'hFF, 8'h00);
        send_event(hmc_pkg::OP_CTRL, hmc_pkg::FK_ACK, 8'h01, 8'hFF, 8'h00);   // not for us
        send_event(hmc_pkg::OP_CTRL, hmc_pkg::FK_ACK, 8'h00, 8'hFF, 8'h00);   // success
        // responder side: DROP and unknown phy frames drop out, data is delivered
        send_event(hmc_pkg::OP_CTRL, hmc_pkg::FK_ACK, 8'h00, 8'h7E, 8'h00);
        send_event(hmc_pkg::OP_PHY, PK_DROP, 8'h00, 8'h7E, 8'h00);
        send_event(hmc_pkg::OP_PHY, PK_OTHER, 8'h00, 8'h7E, 8'h00);
        send_event(hmc_pkg::OP_PHY, hmc_pkg::PK_DATA, 8'h00, 8'h7E, 8'h00);

        // Timeout one: restart after expiry, handshake expiry, expiry seen in idle.
        configure(8'hFF, 32'd1);
        send_event(hmc_pkg::OP_SEND, hmc_pkg::FK_ACK, 8'h00, 8'h00, 8'h3C);
        run_ticks(2);
        send_event(hmc_pkg::OP_SEND, hmc_pkg::FK_ACK, 8'h00, 8'h00, 8'h3C);   // restarts
        run_ticks(2);
        send_event(hmc_pkg::OP_CTRL, hmc_pkg::FK_ACK, 8'hFF, 8'h3C, 8'h00);   // failed
        run_ticks(2);
        send_event(hmc_pkg::OP_PHY, PK_SENSE, 8'hFF, 8'h00, 8'h00);  // failed even in idle

        // Zero timeout: the handshake still passes, the first NACK fails.
        configure(8'hFF, 32'd0);
        send_event(hmc_pkg::OP_SEND, hmc_pkg::FK_ACK, 8'h00, 8'h00, 8'h42);
        send_event(hmc_pkg::OP_CTRL, hmc_pkg::FK_ACK, 8'hFF, 8'h42, 8'h00);
        send_event(hmc_pkg::OP_CTRL, hmc_pkg::FK_NACK, 8'hFF, 8'h42, 8'h00);

        // Random phases, each under its own register values and idle pattern.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            own = (own_tab[ph] < 0) ? 8'($urandom()) : 8'(own_tab[ph]);
            configure(own, tmo_tab[ph]);
            sender_idle_pct = sidle_tab[ph];
            recv_stall_pct  = rstall_tab[ph];
            if (ph == 0)
            begin
                // hold the output while requests keep coming: each one answers
                hold_off_req = 1'b1;
                repeat (12)
                    send_event(hmc_pkg::OP_SEND, 2'($urandom()), 8'($urandom()),
                               8'($urandom()), 8'($urandom()));
            end
            run_phase(PHASE_ITEMS);
        end

        settle();
        repeat (8) @(posedge clk);

        $display("Sent %0d events under %0d register settings; %0d results compared.",
                 items_sent, settings_used, replies_seen);
        $display("Idle patterns: none, sender-heavy, receiver-heavy, mixed, plus one long hold.");
        if (replies_due != 0)
            $display("%0d expected results never arrived", replies_due);
        if (mismatches == 0 && replies_due == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin : watchdog
        #9_600_000;
        $display("Run exceeded its time limit");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
